/* hw/rtl/ftt_pkg.sv */
`timescale 1ns / 1ps

package ftt_pkg;

  localparam logic [2:0] OP_ARM    = 3'd0;
  localparam logic [2:0] OP_DISARM = 3'd1;
  localparam logic [2:0] OP_HIT    = 3'd2;
  localparam logic [2:0] OP_GET    = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVAL    = 2'd1;
  localparam logic [1:0] ST_NOSPACE  = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Contents of one slot, apart from its armed bit.
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] hits;
    logic [31:0] trigger;
    logic [3:0]  code;
  } ftt_entry_t;

  // Update commands from the sequencer to the slot store.
  typedef struct packed {
    logic ent_we;
    logic hits_we;
    logic arm_set;
    logic arm_clr;
    logic clr_all;
  } ftt_ctl_t;

endpackage

/* hw/rtl/ftt_store.sv */
`timescale 1ns / 1ps

module ftt_store #(
  parameter int SLOTS = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  ftt_pkg::ftt_ctl_t                        ctl,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr,
  input  ftt_pkg::ftt_entry_t                      wr_data,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
  output ftt_pkg::ftt_entry_t                      rd_data,
  output logic [SLOTS-1:0]                         armed
);

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [31:0] key_mem  [SLOTS];
  logic [31:0] hits_mem [SLOTS];
  logic [31:0] trig_mem [SLOTS];
  logic [3:0]  code_mem [SLOTS];

  ftt_pkg::ftt_entry_t rd_r;
  logic [SLOTS-1:0]    armed_r;
  logic [SLOTS-1:0]    armed_nxt;

  // The slot fields hold stale data after a disarm or clear; only the
  // armed bits decide whether a slot takes part in a lookup.
  always_ff @(posedge clk) begin
    if (ctl.ent_we) begin
      key_mem[wr_addr[IDXW-1:0]]  <= wr_data.key;
      trig_mem[wr_addr[IDXW-1:0]] <= wr_data.trigger;
      code_mem[wr_addr[IDXW-1:0]] <= wr_data.code;
    end
    if (ctl.ent_we || ctl.hits_we) begin
      hits_mem[wr_addr[IDXW-1:0]] <= wr_data.hits;
    end
    rd_r.key     <= key_mem[rd_addr];
    rd_r.hits    <= hits_mem[rd_addr];
    rd_r.trigger <= trig_mem[rd_addr];
    rd_r.code    <= code_mem[rd_addr];
  end

  always_comb begin
    armed_nxt = armed_r;
    if (ctl.clr_all) begin
      armed_nxt = '0;
    end else if (ctl.arm_set) begin
      armed_nxt[wr_addr] = 1'b1;
    end else if (ctl.arm_clr) begin
      armed_nxt[wr_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= '0;
    end else begin
      armed_r <= armed_nxt;
    end
  end

  assign rd_data = rd_r;
  assign armed   = armed_r;

endmodule

/* hw/rtl/fault_trigger_table_top.sv */
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// in        in_valid / in_ready    in_op, in_key_hash, in_trigger_count, in_fault_code
// out       out_valid / out_ready  out_status, out_fault_out, out_entry_hits,
//                                  out_entry_trigger, out_entry_code
//
// One slot is read per cycle through the store's single read port and checked by
// one shared 32-bit key comparator; the scan stops at the first armed match.
// A scan ends on a match in slot i or, when nothing matches, after the last slot; clear
// and rejected items skip the scan and go straight to the result register.
// Reset clears every armed bit at once, so no clearing pass is needed. A result
// waits in its own register; one more item can finish behind it, then in_ready stays low.

module fault_trigger_table_top #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_key_hash,
  input  logic [31:0] in_trigger_count,
  input  logic [3:0]  in_fault_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_fault_out,
  output logic [31:0] out_entry_hits,
  output logic [31:0] out_entry_trigger,
  output logic [3:0]  out_entry_code
);

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [IDXW-1:0] scan_idx_r, scan_idx_nxt;
  logic            issue_r, issue_nxt;
  logic            cmp_vld_r, cmp_vld_nxt;
  logic [IDXW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic            free_vld_r, free_vld_nxt;
  logic [IDXW-1:0] free_idx_r, free_idx_nxt;

  logic [2:0]  req_op_r, req_op_nxt;
  logic [31:0] req_key_r, req_key_nxt;
  logic [31:0] req_trig_r, req_trig_nxt;
  logic [3:0]  req_code_r, req_code_nxt;

  logic [1:0]  res_status_r, res_status_nxt;
  logic [3:0]  res_fault_r, res_fault_nxt;
  logic [31:0] res_hits_r, res_hits_nxt;
  logic [31:0] res_trig_r, res_trig_nxt;
  logic [3:0]  res_code_r, res_code_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [3:0]  out_fault_r, out_fault_nxt;
  logic [31:0] out_hits_r, out_hits_nxt;
  logic [31:0] out_trig_r, out_trig_nxt;
  logic [3:0]  out_code_r, out_code_nxt;

  ftt_pkg::ftt_ctl_t   ctl;
  ftt_pkg::ftt_entry_t wr_data;
  ftt_pkg::ftt_entry_t rd_data;
  logic [IDXW-1:0]     wr_addr;
  logic [SLOTS-1:0]    armed;

  logic            cur_armed;
  logic            hit_now;
  logic            last_now;
  logic            free_any;
  logic [IDXW-1:0] free_sel;
  logic [31:0]     hits_inc;
  logic            out_free;

  ftt_store #(
    .SLOTS(SLOTS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (scan_idx_r),
    .rd_data (rd_data),
    .armed   (armed)
  );

  // The read data registered in the store belongs to cmp_idx_r.
  assign cur_armed = armed[cmp_idx_r];
  assign hit_now   = cmp_vld_r && cur_armed && (rd_data.key == req_key_r);
  assign last_now  = cmp_vld_r && (cmp_idx_r == LAST_IDX);
  assign free_any  = free_vld_r || (cmp_vld_r && !cur_armed);
  assign free_sel  = free_vld_r ? free_idx_r : cmp_idx_r;
  assign hits_inc  = (rd_data.hits == 32'hFFFF_FFFF) ? rd_data.hits : rd_data.hits + 32'd1;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    scan_idx_nxt   = scan_idx_r;
    issue_nxt      = issue_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    free_vld_nxt   = free_vld_r;
    free_idx_nxt   = free_idx_r;
    req_op_nxt     = req_op_r;
    req_key_nxt    = req_key_r;
    req_trig_nxt   = req_trig_r;
    req_code_nxt   = req_code_r;
    res_status_nxt = res_status_r;
    res_fault_nxt  = res_fault_r;
    res_hits_nxt   = res_hits_r;
    res_trig_nxt   = res_trig_r;
    res_code_nxt   = res_code_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_fault_nxt  = out_fault_r;
    out_hits_nxt   = out_hits_r;
    out_trig_nxt   = out_trig_r;
    out_code_nxt   = out_code_r;
    ctl            = '0;
    wr_addr        = cmp_idx_r;
    wr_data.key     = req_key_r;
    wr_data.hits    = 32'd0;
    wr_data.trigger = req_trig_r;
    wr_data.code    = req_code_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_op_nxt     = in_op;
          req_key_nxt    = in_key_hash;
          req_trig_nxt   = in_trigger_count;
          req_code_nxt   = in_fault_code;
          scan_idx_nxt   = '0;
          issue_nxt      = 1'b1;
          free_vld_nxt   = 1'b0;
          res_status_nxt = ftt_pkg::ST_OK;
          res_fault_nxt  = 4'd0;
          res_hits_nxt   = 32'd0;
          res_trig_nxt   = 32'd0;
          res_code_nxt   = 4'd0;
          if (in_op == ftt_pkg::OP_CLEAR) begin
            ctl.clr_all = 1'b1;
            state_nxt   = S_HOLD;
          end else if (in_op > ftt_pkg::OP_CLEAR ||
                       (in_op == ftt_pkg::OP_ARM &&
                        (in_trigger_count == 32'd0 || in_fault_code == 4'd0))) begin
            res_status_nxt = ftt_pkg::ST_INVAL;
            state_nxt      = S_HOLD;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Read of the next slot overlaps the compare of the previous one.
        cmp_vld_nxt = issue_r;
        cmp_idx_nxt = scan_idx_r;
        if (issue_r) begin
          scan_idx_nxt = scan_idx_r + IDXW'(1);
          issue_nxt    = (scan_idx_r != LAST_IDX);
        end
        if (cmp_vld_r && !cur_armed && !free_vld_r) begin
          free_vld_nxt = 1'b1;
          free_idx_nxt = cmp_idx_r;
        end
        if (hit_now || last_now) begin
          state_nxt = S_HOLD;
          issue_nxt = 1'b0;
          unique case (req_op_r)
            ftt_pkg::OP_ARM: begin
              if (hit_now || free_any) begin
                wr_addr     = hit_now ? cmp_idx_r : free_sel;
                ctl.ent_we  = 1'b1;
                ctl.arm_set = 1'b1;
              end else begin
                res_status_nxt = ftt_pkg::ST_NOSPACE;
              end
            end
            ftt_pkg::OP_DISARM: begin
              ctl.arm_clr = hit_now;
            end
            ftt_pkg::OP_HIT: begin
              if (hit_now) begin
                wr_data.hits  = hits_inc;
                ctl.hits_we   = 1'b1;
                res_fault_nxt = (hits_inc == rd_data.trigger) ? rd_data.code : 4'd0;
              end
            end
            ftt_pkg::OP_GET: begin
              if (hit_now) begin
                res_hits_nxt = rd_data.hits;
                res_trig_nxt = rd_data.trigger;
                res_code_nxt = rd_data.code;
              end else begin
                res_status_nxt = ftt_pkg::ST_NOTFOUND;
              end
            end
            default: begin
              res_status_nxt = ftt_pkg::ST_INVAL;
            end
          endcase
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_fault_nxt  = res_fault_r;
          out_hits_nxt   = res_hits_r;
          out_trig_nxt   = res_trig_r;
          out_code_nxt   = res_code_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      free_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      free_vld_r  <= free_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r   <= scan_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    req_op_r     <= req_op_nxt;
    req_key_r    <= req_key_nxt;
    req_trig_r   <= req_trig_nxt;
    req_code_r   <= req_code_nxt;
    res_status_r <= res_status_nxt;
    res_fault_r  <= res_fault_nxt;
    res_hits_r   <= res_hits_nxt;
    res_trig_r   <= res_trig_nxt;
    res_code_r   <= res_code_nxt;
    out_status_r <= out_status_nxt;
    out_fault_r  <= out_fault_nxt;
    out_hits_r   <= out_hits_nxt;
    out_trig_r   <= out_trig_nxt;
    out_code_r   <= out_code_nxt;
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_fault_out     = out_fault_r;
  assign out_entry_hits    = out_hits_r;
  assign out_entry_trigger = out_trig_r;
  assign out_entry_code    = out_code_r;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("accepted transfer did not start an operation");

  a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.ent_we, ctl.hits_we, ctl.arm_clr, ctl.clr_all}))
    else $error("more than one table update in a cycle");

  a_arm_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ent_we |-> (req_trig_r != 32'd0) && (req_code_r != 4'd0) && ctl.arm_set)
    else $error("slot armed with an invalid trigger or code");

  a_hold_drains: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HOLD && out_free |=> state_r == S_IDLE && out_valid_r)
    else $error("finished result was not moved to the output register");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int SLOTS = 8;
  localparam int NO_SLOT = -1;
  localparam int KEY_POOL = 12;
  localparam int LONG_HOLD = 80;
  localparam int PHASE_ITEMS = 446;
  localparam logic [31:0] ALL_ONES = '1;
  localparam logic [2:0] OP_UNUSED_LO = ftt_pkg::OP_CLEAR + 3'd1;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] key;
    logic [31:0] trig;
    logic [3:0]  code;
  } trigger_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  fault;
    logic [31:0] hits;
    logic [31:0] trig;
    logic [3:0]  code;
  } table_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_op = '0;
  logic [31:0] in_key_hash = '0;
  logic [31:0] in_trigger_count = '0;
  logic [3:0]  in_fault_code = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [3:0]  out_fault_out;
  logic [31:0] out_entry_hits;
  logic [31:0] out_entry_trigger;
  logic [3:0]  out_entry_code;

  fault_trigger_table_top #(
    .SLOTS(SLOTS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_key_hash      (in_key_hash),
    .in_trigger_count (in_trigger_count),
    .in_fault_code    (in_fault_code),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_fault_out    (out_fault_out),
    .out_entry_hits   (out_entry_hits),
    .out_entry_trigger(out_entry_trigger),
    .out_entry_code   (out_entry_code)
  );

  // Shadow copy of the trigger table.
  logic [31:0] tbl_key   [SLOTS];
  logic [31:0] tbl_hits  [SLOTS];
  logic [31:0] tbl_trig  [SLOTS];
  logic [3:0]  tbl_code  [SLOTS];
  logic        tbl_armed [SLOTS];

  trigger_cmd_t cmd_queue[$];
  table_reply_t expected_replies[$];
  logic [31:0]  key_pool[KEY_POOL];

  logic in_taken = 1'b0;
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  int   holds_asked = 0;
  int   holds_served = 0;
  int   hold_left = 0;
  int   mismatches = 0;
  int   replies_checked = 0;
  int   faults_fired = 0;
  int   full_rejects = 0;
  int   get_misses = 0;
  int   invalid_seen = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int find_armed(input logic [31:0] k);
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_armed[i] && tbl_key[i] == k) return i;
    end
    return NO_SLOT;
  endfunction

  // Applies one command to the shadow table and returns the reply it must produce.
  function automatic table_reply_t table_apply(input trigger_cmd_t c);
    table_reply_t r;
    int s;
    r = '0;
    s = NO_SLOT;
    case (c.op)
      ftt_pkg::OP_ARM: begin
        if (c.trig == '0 || c.code == '0) begin
          r.status = ftt_pkg::ST_INVAL;
        end else begin
          s = find_armed(c.key);
          for (int i = 0; i < SLOTS && s == NO_SLOT; i++) begin
            if (!tbl_armed[i]) s = i;
          end
          if (s == NO_SLOT) begin
            r.status = ftt_pkg::ST_NOSPACE;
          end else begin
            tbl_key[s]   = c.key;
            tbl_hits[s]  = '0;
            tbl_trig[s]  = c.trig;
            tbl_code[s]  = c.code;
            tbl_armed[s] = 1'b1;
          end
        end
      end
      ftt_pkg::OP_DISARM: begin
        s = find_armed(c.key);
        if (s != NO_SLOT) begin
          tbl_key[s]   = '0;
          tbl_hits[s]  = '0;
          tbl_trig[s]  = '0;
          tbl_code[s]  = '0;
          tbl_armed[s] = 1'b0;
        end
      end
      ftt_pkg::OP_HIT: begin
        s = find_armed(c.key);
        if (s != NO_SLOT) begin
          if (tbl_hits[s] != ALL_ONES) tbl_hits[s] = tbl_hits[s] + 32'd1;
          if (tbl_hits[s] == tbl_trig[s]) r.fault = tbl_code[s];
        end
      end
      ftt_pkg::OP_GET: begin
        s = find_armed(c.key);
        if (s == NO_SLOT) begin
          r.status = ftt_pkg::ST_NOTFOUND;
        end else begin
          r.hits = tbl_hits[s];
          r.trig = tbl_trig[s];
          r.code = tbl_code[s];
        end
      end
      ftt_pkg::OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          tbl_key[i]   = '0;
          tbl_hits[i]  = '0;
          tbl_trig[i]  = '0;
          tbl_code[i]  = '0;
          tbl_armed[i] = 1'b0;
        end
      end
      default: r.status = ftt_pkg::ST_INVAL;
    endcase
    return r;
  endfunction

  task automatic queue_cmd(input logic [2:0] op, input logic [31:0] key,
                           input logic [31:0] trig, input logic [3:0] code);
    trigger_cmd_t c;
    c.op = op;
    c.key = key;
    c.trig = trig;
    c.code = code;
    cmd_queue.push_back(c);
  endtask

  // Mostly a small pool of keys so that arms, hits and disarms land on the same
  // entries; the pool is larger than the table, so it also runs out of space.
  function automatic trigger_cmd_t random_cmd();
    trigger_cmd_t c;
    int pick;
    if ($urandom_range(9) == 0) c.key = $urandom();
    else c.key = key_pool[$urandom_range(KEY_POOL - 1)];
    c.trig = $urandom();
    c.code = 4'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 34) begin
      c.op = ftt_pkg::OP_ARM;
      case ($urandom_range(9))
        0: c.trig = '0;
        1: c.trig = ALL_ONES - 32'($urandom_range(3));
        2: ;
        default: c.trig = 32'($urandom_range(6, 1));
      endcase
      if ($urandom_range(11) != 0) c.code = 4'($urandom_range(15, 1));
    end else if (pick < 64) begin
      c.op = ftt_pkg::OP_HIT;
    end else if (pick < 78) begin
      c.op = ftt_pkg::OP_GET;
    end else if (pick < 92) begin
      c.op = ftt_pkg::OP_DISARM;
    end else if (pick < 94) begin
      c.op = ftt_pkg::OP_CLEAR;
    end else begin
      c.op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    end
    return c;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Checked at the rising edge, where the driver's last update has settled.
  task automatic drain_all();
    while (cmd_queue.size() != 0 || in_valid || expected_replies.size() != 0) begin
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  // Driver: presents the next command on the falling edge once the last one is taken.
  always @(negedge clk) begin
    trigger_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (cmd_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        c = cmd_queue.pop_front();
        in_valid <= 1'b1;
        in_op <= c.op;
        in_key_hash <= c.key;
        in_trigger_count <= c.trig;
        in_fault_code <= c.code;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_asked != holds_served) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      holds_served <= holds_served + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Monitor: checks each result transfer, then predicts for each input transfer.
  always @(posedge clk) begin
    table_reply_t want;
    trigger_cmd_t c;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: result transfer with nothing expected, status %0h", $time,
                   out_status);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          replies_checked++;
          if (want.fault != '0) faults_fired++;
          if (want.status == ftt_pkg::ST_NOSPACE) full_rejects++;
          if (want.status == ftt_pkg::ST_NOTFOUND) get_misses++;
          if (want.status == ftt_pkg::ST_INVAL) invalid_seen++;
          report_field("status", 32'(want.status), 32'(out_status));
          report_field("fault_out", 32'(want.fault), 32'(out_fault_out));
          report_field("entry_hits", want.hits, out_entry_hits);
          report_field("entry_trigger", want.trig, out_entry_trigger);
          report_field("entry_code", 32'(want.code), 32'(out_entry_code));
        end
      end
      if (in_valid && in_ready) begin
        c.op = in_op;
        c.key = in_key_hash;
        c.trig = in_trigger_count;
        c.code = in_fault_code;
        expected_replies.push_back(table_apply(c));
      end
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_key[i]   = '0;
      tbl_hits[i]  = '0;
      tbl_trig[i]  = '0;
      tbl_code[i]  = '0;
      tbl_armed[i] = 1'b0;
    end
    key_pool[0] = '0;
    key_pool[1] = ALL_ONES;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // Directed checks on an empty table, then arm, fire, rewrite and fill it.
    queue_cmd(ftt_pkg::OP_GET, '0, '0, '0);
    queue_cmd(ftt_pkg::OP_HIT, 32'h0000_0042, ALL_ONES, 4'hf);
    queue_cmd(ftt_pkg::OP_DISARM, 32'h0000_0042, '0, '0);
    queue_cmd(ftt_pkg::OP_ARM, 32'h0000_0042, '0, 4'h3);
    queue_cmd(ftt_pkg::OP_ARM, 32'h0000_0042, 32'd5, '0);
    queue_cmd(ftt_pkg::OP_ARM, '0, 32'd2, 4'hf);
    queue_cmd(ftt_pkg::OP_HIT, '0, '0, '0);
    queue_cmd(ftt_pkg::OP_HIT, '0, '0, '0);
    queue_cmd(ftt_pkg::OP_HIT, '0, '0, '0);
    queue_cmd(ftt_pkg::OP_GET, '0, '0, '0);
    queue_cmd(ftt_pkg::OP_ARM, '0, ALL_ONES, 4'h1);
    queue_cmd(ftt_pkg::OP_GET, '0, '0, '0);
    for (int k = 1; k < SLOTS; k++) begin
      queue_cmd(ftt_pkg::OP_ARM, (k == 1) ? ALL_ONES : 32'(k), 32'(k), 4'(k));
    end
    queue_cmd(ftt_pkg::OP_ARM, 32'h1234_5678, 32'd1, 4'h9);
    queue_cmd(ftt_pkg::OP_DISARM, 32'd3, '0, '0);
    queue_cmd(ftt_pkg::OP_ARM, 32'hA5A5_A5A5, 32'd1, 4'h7);
    queue_cmd(ftt_pkg::OP_HIT, 32'hA5A5_A5A5, '0, '0);
    for (int o = OP_UNUSED_LO; o <= OP_UNUSED_HI; o++) begin
      queue_cmd(3'(o), ALL_ONES, ALL_ONES, 4'hf);
    end
    queue_cmd(ftt_pkg::OP_CLEAR, '0, '0, '0);
    queue_cmd(ftt_pkg::OP_GET, ALL_ONES, '0, '0);
    drain_all();

    // Hold the output off for a long stretch while commands keep coming.
    holds_asked = holds_asked + 1;
    repeat (40) cmd_queue.push_back(random_cmd());
    drain_all();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 72; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 72; end
        default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
      endcase
      repeat (PHASE_ITEMS) cmd_queue.push_back(random_cmd());
      drain_all();
    end

    repeat (3 * (SLOTS + 2)) @(posedge clk);
    $display("summary: %0d results checked, %0d faults fired, %0d full-table rejects,",
             replies_checked, faults_fired, full_rejects);
    $display("summary: %0d lookups missed, %0d invalid requests, idle and stall phases run",
             get_misses, invalid_seen);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
